[hdl/shfp_pkg.sv]
package shfp_pkg;

  localparam logic [7:0] TERM_BYTE = 8'h3e;
  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam int HDR_BYTES = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LOAD
  } state_t;

endpackage

[hdl/shfp_if.sv]
interface shfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface shfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_type;
  logic [5:0] frame_len;
  logic [7:0] payload_byte;
  logic [5:0] payload_pos;
  logic       payload_valid;
  logic       last;
  logic       len_clamped;

  modport source (output valid, output frame_type, output frame_len, output payload_byte,
                  output payload_pos, output payload_valid, output last,
                  output len_clamped, input ready);
  modport sink (input valid, input frame_type, input frame_len, input payload_byte,
                input payload_pos, input payload_valid, input last, input len_clamped,
                output ready);
endinterface

[hdl/sync_header_frame_parser_unit.sv]
// An ordinary byte is written to the frame store; a terminator after a valid sync header
// starts a run, whose first word is registered once the output register is free.
// Throughput: one byte per cycle while a frame is being collected; each result word
// of a run passes through the run and load states, with a registered read of the frame store.
// Reset: synchronous, active low; it empties the frame and clears the output valid flag.
// The frame store itself is not cleared.
module sync_header_frame_parser_unit #(
  parameter int STORE_DEPTH = 64
) (
  input logic         clk,
  input logic         rst_n,
  shfp_in_if.sink     in_ch,
  shfp_out_if.source  out_ch
);
  import shfp_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int FW  = $clog2(STORE_DEPTH + 1);
  localparam int CAP = STORE_DEPTH - HDR_BYTES;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_q;

  state_t          state_r, state_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [7:0]      hdr_r [HDR_BYTES];
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   len_r, len_nxt;
  logic [7:0]      type_r, type_nxt;
  logic            clamp_r, clamp_nxt;
  logic            pay_ok_r, pay_ok_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      o_type_r, o_byte_r;
  logic [5:0]      o_len_r, o_pos_r;
  logic            o_pv_r, o_last_r, o_clamp_r;

  logic            in_fire, is_term, wr_en, sync_ok, clamp_now, is_last;
  logic [7:0]      hdr_rd [HDR_BYTES];
  logic [AW-1:0]   rd_addr;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign is_term = (in_ch.rx_byte == TERM_BYTE);
  assign wr_en   = in_fire && !is_term && (fill_r < FW'(STORE_DEPTH));
  assign rd_addr = AW'(HDR_BYTES) + idx_r;
  assign is_last = ({1'b0, idx_r} + 1'b1) >= {1'b0, len_r};

  always_comb begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_rd[k] = (fill_r > FW'(k)) ? hdr_r[k] : 8'h00;
    end
  end

  assign sync_ok   = (hdr_rd[0] == SYNC_BYTE) && (hdr_rd[1] == SYNC_BYTE);
  assign clamp_now = 32'(hdr_rd[3]) > 32'(CAP);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= in_ch.rx_byte;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      if (wr_en && (fill_r == FW'(k))) begin
        hdr_r[k] <= in_ch.rx_byte;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && is_term && sync_ok) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = is_last ? ST_IDLE : ST_RUN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    type_nxt      = type_r;
    clamp_nxt     = clamp_r;
    pay_ok_nxt    = pay_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (wr_en) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (in_fire && is_term) begin
          if (sync_ok) begin
            type_nxt  = hdr_rd[2];
            clamp_nxt = clamp_now;
            len_nxt   = clamp_now ? AW'(CAP) : hdr_rd[3][AW-1:0];
            idx_nxt   = '0;
          end else begin
            fill_nxt = '0;
          end
        end
      end
      ST_RUN: begin
        pay_ok_nxt = FW'(rd_addr) < fill_r;
      end
      ST_LOAD: begin
        out_valid_nxt = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        if (is_last) begin
          fill_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r    <= idx_nxt;
    len_r    <= len_nxt;
    type_r   <= type_nxt;
    clamp_r  <= clamp_nxt;
    pay_ok_r <= pay_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      o_type_r  <= type_r;
      o_len_r   <= 6'(len_r);
      o_byte_r  <= (pay_ok_r && (len_r != '0)) ? rd_q : 8'h00;
      o_pos_r   <= 6'(idx_r);
      o_pv_r    <= (len_r != '0);
      o_last_r  <= is_last;
      o_clamp_r <= clamp_r;
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_type    = o_type_r;
  assign out_ch.frame_len     = o_len_r;
  assign out_ch.payload_byte  = o_byte_r;
  assign out_ch.payload_pos   = o_pos_r;
  assign out_ch.payload_valid = o_pv_r;
  assign out_ch.last          = o_last_r;
  assign out_ch.len_clamped   = o_clamp_r;

endmodule

[hdl/shfp_checker.sv]
module shfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic [5:0] payload_pos,
  input logic [5:0] frame_len,
  input logic       payload_valid,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(payload_pos))
    else $error("A stalled result word changed.");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !payload_valid |-> payload_byte == 8'h00 && payload_pos == 6'd0 && last)
    else $error("An empty payload word is malformed.");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && payload_valid && last |-> 6'(payload_pos + 6'd1) == frame_len)
    else $error("The final word does not sit at the end of the payload.");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("Input accepted while a run was still being emitted.");

endmodule

bind sync_header_frame_parser_unit shfp_checker u_shfp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .payload_byte (out_ch.payload_byte),
  .payload_pos  (out_ch.payload_pos),
  .frame_len    (out_ch.frame_len),
  .payload_valid(out_ch.payload_valid),
  .last         (out_ch.last)
);
